[hdl/mcpg_pkg.sv]
// mcpg_pkg: shared types, field widths and register indexes of the
// min-cost cylinder path block. No dependencies.
`default_nettype none

package mcpg_pkg;

	localparam int WEIGHT_W   = 8;
	localparam int COST_W     = 14;
	localparam int NUM_ROWS_W = 6;
	localparam int NUM_COLS_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

	localparam int RESET_NUM_ROWS = 5;
	localparam int RESET_NUM_COLS = 6;

	typedef logic [COST_W-1:0]   cost_t;
	typedef logic [WEIGHT_W-1:0] weight_t;

	localparam cost_t COST_ALL_ONES = '1;

	// one finished grid
	typedef struct packed {
		logic  valid;
		cost_t cost;
	} res_t;

endpackage

`default_nettype wire

[hdl/mcpg_ram.sv]
// mcpg_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module mcpg_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                        wr_data,
	input  wire logic                                    rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read during write to the same address returns the old word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hdl/mcpg_cfg.sv]
// mcpg_cfg: row and column count registers, clamped to the supported range
// and kept as last-index values. Depends on mcpg_pkg.
`default_nettype none

module mcpg_cfg
	import mcpg_pkg::*;
#(
	parameter int ROWS_MAX = 32,
	parameter int COLS_MAX = 64
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         cfg_valid,
	output logic                                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]                         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]                        cfg_data,
	output logic      [(ROWS_MAX > 1 ? $clog2(ROWS_MAX) : 1)-1:0] rows_last,
	output logic      [(COLS_MAX > 1 ? $clog2(COLS_MAX) : 1)-1:0] cols_last,
	output logic                                              restart
);

	localparam int AW = ROWS_MAX > 1 ? $clog2(ROWS_MAX) : 1;
	localparam int CW = COLS_MAX > 1 ? $clog2(COLS_MAX) : 1;

	// zero acts as one, above the maximum acts as the maximum
	function automatic int clamp_last(input int v, input int hi);
		int r;
		if (v == 0) begin
			r = 0;
		end else if (v > hi) begin
			r = hi - 1;
		end else begin
			r = v - 1;
		end
		return r;
	endfunction

	localparam logic [AW-1:0] ROWS_LAST_RST = AW'(clamp_last(RESET_NUM_ROWS, ROWS_MAX));
	localparam logic [CW-1:0] COLS_LAST_RST = CW'(clamp_last(RESET_NUM_COLS, COLS_MAX));

	logic          wr;
	logic [AW-1:0] rows_last_q;
	logic [CW-1:0] cols_last_q;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;
	assign restart   = wr & ((cfg_index == REG_NUM_ROWS) | (cfg_index == REG_NUM_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_last_q <= ROWS_LAST_RST;
			cols_last_q <= COLS_LAST_RST;
		end else if (wr) begin
			if (cfg_index == REG_NUM_ROWS) begin
				rows_last_q <= AW'(clamp_last(int'(cfg_data[NUM_ROWS_W-1:0]), ROWS_MAX));
			end
			if (cfg_index == REG_NUM_COLS) begin
				cols_last_q <= CW'(clamp_last(int'(cfg_data[NUM_COLS_W-1:0]), COLS_MAX));
			end
		end
	end

	assign rows_last = rows_last_q;
	assign cols_last = cols_last_q;

endmodule

`default_nettype wire

[hdl/mcpg_dp.sv]
// mcpg_dp: column cost engine. Costs live in one RAM, written in place row by
// row; a three-entry window plus the column's row 0 cost cover the wrap.
// Depends on mcpg_pkg and mcpg_ram.
`default_nettype none

module mcpg_dp
	import mcpg_pkg::*;
#(
	parameter int ROWS_MAX = 32,
	parameter int COLS_MAX = 64
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic [(ROWS_MAX > 1 ? $clog2(ROWS_MAX) : 1)-1:0] rows_last,
	input  wire logic [(COLS_MAX > 1 ? $clog2(COLS_MAX) : 1)-1:0] cols_last,
	input  wire logic                                         restart,
	input  wire logic                                         in_fire,
	input  wire weight_t                                      weight,
	output res_t                                              res
);

	localparam int AW = ROWS_MAX > 1 ? $clog2(ROWS_MAX) : 1;
	localparam int CW = COLS_MAX > 1 ? $clog2(COLS_MAX) : 1;

	logic [AW-1:0] row_q;
	logic [CW-1:0] col_q;
	cost_t         min_q;
	cost_t         up_q;        // previous column, row above
	cost_t         mid_q;       // previous column, same row
	cost_t         first_q;     // previous column, row 0
	cost_t         cur0_q;      // current column, row 0
	logic          fwd_q;
	cost_t         fwd_cost_q;

	logic          last_row;
	logic          last_col;
	logic          first_col;
	cost_t         rd_data;
	cost_t         mem_down;
	cost_t         down;
	cost_t         best_um;
	cost_t         best;
	cost_t         cost;
	cost_t         c0;
	cost_t         new_min;
	logic [AW-1:0] rd_addr;

	assign last_row  = (row_q == rows_last);
	assign last_col  = (col_q == cols_last);
	assign first_col = (col_q == '0);

	// the read whose data arrives now collided with the write of the same entry
	assign mem_down = fwd_q ? fwd_cost_q : rd_data;
	assign down     = last_row ? first_q : mem_down;

	assign best_um = (up_q < mid_q) ? up_q : mid_q;
	assign best    = (down < best_um) ? down : best_um;
	assign cost    = first_col ? COST_W'(weight) : COST_W'(weight) + best;
	assign c0      = (row_q == '0) ? cost : cur0_q;
	assign new_min = (last_col && (cost < min_q)) ? cost : min_q;

	// fetch the down neighbor of the next row: row 1 once the column wraps
	assign rd_addr = last_row ? AW'(1) : AW'(row_q + AW'(2));

	mcpg_ram #(
		.WIDTH (COST_W),
		.DEPTH (ROWS_MAX)
	) u_ram (
		.clk     (clk),
		.wr_en   (in_fire),
		.wr_addr (row_q),
		.wr_data (cost),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			min_q <= COST_ALL_ONES;
			fwd_q <= 1'b0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
			min_q <= COST_ALL_ONES;
		end else if (in_fire) begin
			fwd_q <= (rd_addr == row_q);
			if (last_row) begin
				row_q <= '0;
				if (last_col) begin
					col_q <= '0;
					min_q <= COST_ALL_ONES;
				end else begin
					col_q <= col_q + CW'(1);
					min_q <= new_min;
				end
			end else begin
				row_q <= row_q + AW'(1);
				min_q <= new_min;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			fwd_cost_q <= cost;
			cur0_q     <= c0;
			if (last_row) begin
				up_q    <= cost;
				mid_q   <= c0;
				first_q <= c0;
			end else begin
				up_q  <= mid_q;
				mid_q <= mem_down;
			end
		end
	end

	assign res.valid = in_fire & last_row & last_col;
	assign res.cost  = new_min;

endmodule

`default_nettype wire

[hdl/min_cost_path_grid_wrap.sv]
// min_cost_path_grid_wrap: top level, output register and handshake.
// Depends on mcpg_pkg, mcpg_cfg, mcpg_dp.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | in_valid, in_stall, weight[7:0]       | in
//   output  | out_valid, out_stall, min_cost[13:0]  | out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// one weight word per cycle while in_stall is low; each weight is a read-modify-write
// of the cost RAM plus a three-way minimum and an add.
// the result word is registered and appears in the cycle after the grid's last weight.
// in_stall is high only while a result word waits and out_stall holds it.
// reset needs no clearing pass; row and column count writes restart the grid at row 0.
`default_nettype none

module min_cost_path_grid_wrap
	import mcpg_pkg::*;
#(
	parameter int ROWS_MAX = 32,
	parameter int COLS_MAX = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [WEIGHT_W-1:0]   weight,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [COST_W-1:0]     min_cost,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = ROWS_MAX > 1 ? $clog2(ROWS_MAX) : 1;
	localparam int CW = COLS_MAX > 1 ? $clog2(COLS_MAX) : 1;

	logic [AW-1:0] rows_last;
	logic [CW-1:0] cols_last;
	logic          restart;
	logic          in_fire;
	res_t          res;
	logic          out_valid_q;
	cost_t         min_cost_q;

	mcpg_cfg #(
		.ROWS_MAX (ROWS_MAX),
		.COLS_MAX (COLS_MAX)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rows_last (rows_last),
		.cols_last (cols_last),
		.restart   (restart)
	);

	assign in_stall = out_valid_q & out_stall;
	assign in_fire  = in_valid & ~in_stall;

	mcpg_dp #(
		.ROWS_MAX (ROWS_MAX),
		.COLS_MAX (COLS_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rows_last (rows_last),
		.cols_last (cols_last),
		.restart   (restart),
		.in_fire   (in_fire),
		.weight    (weight),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			min_cost_q <= res.cost;
		end
	end

	assign out_valid = out_valid_q;
	assign min_cost  = min_cost_q;

endmodule

`default_nettype wire

[hdl/mcpg_chk.sv]
// mcpg_chk: port-level checks of the top level, attached by bind.
// Depends on mcpg_pkg and min_cost_path_grid_wrap.
`default_nettype none

module mcpg_chk
	import mcpg_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [COST_W-1:0]     min_cost,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(min_cost))
		else $error("result word changed while stalled");

	// input stalls only behind a waiting result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// a new result follows an accepted weight
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result without an accepted weight");

	// config port never pushes back
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config word refused");

endmodule

bind min_cost_path_grid_wrap mcpg_chk u_mcpg_chk (.*);

`default_nettype wire

[verif/min_cost_path_grid_wrap_tb.sv]
// min_cost_path_grid_wrap_tb: self-checking bench for the cylinder min-cost path block.
// Streams weight grids under several shapes and pacing modes and checks each
// result word against an in-bench cost predictor. Depends on mcpg_pkg and the RTL.

module min_cost_path_grid_wrap_tb
	import mcpg_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS_MAX    = 32;
	localparam int COLS_MAX    = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS  = 1900;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	weight_t               weight    = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	cost_t                 min_cost;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// stimulus queues and progress counters
	weight_t    pending_weights[$];
	reg_write_t pending_regs[$];
	int         weights_queued = 0;
	int         weights_taken  = 0;
	int         regs_queued    = 0;
	int         regs_taken     = 0;
	int         sender_idle_pct = 0;
	int         recv_stall_pct  = 0;
	int         phase_num   = 0;
	int         idle_cycles = 0;
	int         fail_count  = 0;

	// predictor state
	logic [NUM_ROWS_W-1:0] grid_rows = NUM_ROWS_W'(RESET_NUM_ROWS);
	logic [NUM_COLS_W-1:0] grid_cols = NUM_COLS_W'(RESET_NUM_COLS);
	cost_t prev_col[ROWS_MAX];
	cost_t cur_col[ROWS_MAX];
	int    row_pos = 0;
	int    col_pos = 0;
	cost_t col_min = COST_ALL_ONES;
	cost_t min_cost_q[$];
	cost_t next_min_cost;

	min_cost_path_grid_wrap #(
		.ROWS_MAX(ROWS_MAX),
		.COLS_MAX(COLS_MAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.weight   (weight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.min_cost (min_cost),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	function automatic int clamp_count(input int v, input int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	task automatic restart_grid();
		row_pos = 0;
		col_pos = 0;
		col_min = COST_ALL_ONES;
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_NUM_ROWS: begin
				grid_rows = data[NUM_ROWS_W-1:0];
				restart_grid();
			end
			REG_NUM_COLS: begin
				grid_cols = data[NUM_COLS_W-1:0];
				restart_grid();
			end
			default: ;
		endcase
	endtask

	// one cell of the forward pass; pushes the column minimum when a grid completes
	task automatic advance_grid(input weight_t w);
		int    rows, cols, r, up, dn;
		cost_t best, cost;
		rows = clamp_count(grid_rows, ROWS_MAX);
		cols = clamp_count(grid_cols, COLS_MAX);
		r = (row_pos >= rows) ? rows - 1 : row_pos;
		if (col_pos == 0) begin
			cost = cost_t'(w);
		end else begin
			up = (r == 0) ? rows - 1 : r - 1;
			dn = (r + 1 >= rows) ? 0 : r + 1;
			best = prev_col[r];
			if (prev_col[up] < best)
				best = prev_col[up];
			if (prev_col[dn] < best)
				best = prev_col[dn];
			cost = best + cost_t'(w);
		end
		cur_col[r] = cost;
		if (col_pos + 1 >= cols && cost < col_min)
			col_min = cost;
		if (r + 1 < rows) begin
			row_pos = r + 1;
		end else begin
			prev_col = cur_col;
			row_pos = 0;
			if (col_pos + 1 < cols) begin
				col_pos++;
			end else begin
				min_cost_q.push_back(col_min);
				restart_grid();
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// weight driver: holds a word until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			weight <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_grid(weight);
				weights_taken <= weights_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_weights.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					weight <= pending_weights.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// register write driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				regs_taken <= regs_taken + 1;
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_regs.size() != 0) begin
					cfg_valid <= 1'b1;
					cfg_index <= pending_regs[0].idx;
					cfg_data <= pending_regs[0].data;
					void'(pending_regs.pop_front());
				end else
					cfg_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (min_cost_q.size() == 0) begin
				report_mismatch($sformatf("result word %0d with none expected", min_cost));
			end else begin
				next_min_cost = min_cost_q.pop_front();
				if (min_cost !== next_min_cost)
					report_mismatch($sformatf("min_cost %0d, expected %0d",
						min_cost, next_min_cost));
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("min_cost_path_grid_wrap test failed");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				sender_idle_pct = 0;
				recv_stall_pct = 0;
			end
			PACE_SEND_GAPS: begin
				sender_idle_pct = 74;
				recv_stall_pct = 0;
			end
			PACE_RECV_STALLS: begin
				sender_idle_pct = 0;
				recv_stall_pct = 74;
			end
			default: begin
				sender_idle_pct = 12;
				recv_stall_pct = 12;
			end
		endcase
	endtask

	task automatic feed(input weight_t w);
		pending_weights.push_back(w);
		weights_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		reg_write_t wr;
		wr.idx = idx;
		wr.data = CFG_DATA_W'(data);
		pending_regs.push_back(wr);
		regs_queued++;
		while (regs_taken != regs_queued)
			@(posedge clk);
	endtask

	// drain all weights and results, then cover the output register latency
	task automatic finish_phase();
		while (weights_taken != weights_queued || min_cost_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic feed_grids(input int er, input int ec, input int grids, input bit partial,
		input bit all_max);
		int cells, total, pick;
		cells = er * ec;
		total = grids * cells;
		if (partial && cells > 1)
			total += $urandom_range(cells - 1, 1);
		for (int i = 0; i < total; i++) begin
			pick = $urandom_range(7);
			if (all_max || pick == 0)
				feed(8'hff);
			else if (pick == 1)
				feed(8'h00);
			else
				feed(weight_t'($urandom_range(255)));
		end
		finish_phase();
	endtask

	task automatic run_phase(input int rows_d, input int cols_d, input int grids,
		input bit partial, input bit all_max);
		set_pace(pace_t'(phase_num % 4));
		phase_num++;
		if ($urandom_range(5) == 0)
			write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, $urandom_range(127));
		if ($urandom_range(1)) begin
			write_reg(REG_NUM_ROWS, rows_d);
			write_reg(REG_NUM_COLS, cols_d);
		end else begin
			write_reg(REG_NUM_COLS, cols_d);
			write_reg(REG_NUM_ROWS, rows_d);
		end
		feed_grids(clamp_count(rows_d % 64, ROWS_MAX), clamp_count(cols_d % 128, COLS_MAX),
			grids, partial, all_max);
	endtask

	initial begin
		int sel, rows_d, cols_d, grids;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shape left by reset
		set_pace(PACE_FULL);
		feed_grids(RESET_NUM_ROWS, RESET_NUM_COLS, 2, 1'b1, 1'b0);

		// zero row and column counts act as one: every word is a whole grid
		set_pace(PACE_SEND_GAPS);
		write_reg(REG_NUM_ROWS, 7'h40);
		write_reg(REG_NUM_COLS, 7'h00);
		feed(8'h00);
		feed(8'hff);
		feed(8'h55);
		feed(8'haa);
		finish_phase();

		// bottom row reaches the top row of the previous column
		set_pace(PACE_RECV_STALLS);
		write_reg(REG_NUM_ROWS, 3);
		write_reg(REG_NUM_COLS, 2);
		feed(8'd0);
		feed(8'd255);
		feed(8'd255);
		feed(8'd255);
		feed(8'd255);
		feed(8'd0);
		finish_phase();

		// single row: neighbors are the row itself
		set_pace(PACE_BOTH);
		write_reg(REG_NUM_ROWS, 1);
		write_reg(REG_NUM_COLS, 3);
		feed(8'd10);
		feed(8'd20);
		feed(8'd30);
		finish_phase();

		// a register write in mid-grid restarts the grid
		set_pace(PACE_FULL);
		write_reg(REG_NUM_ROWS, 2);
		write_reg(REG_NUM_COLS, 2);
		feed(8'd7);
		feed(8'd9);
		feed(8'd11);
		finish_phase();
		write_reg(REG_NUM_COLS, 2);
		feed(8'd1);
		feed(8'd2);
		feed(8'd3);
		feed(8'd4);
		finish_phase();

		// writes to unused indexes change nothing and do not restart
		write_reg(REG_UNUSED_2, 7'h7f);
		write_reg(REG_NUM_ROWS, 1);
		write_reg(REG_NUM_COLS, 2);
		feed(8'd100);
		finish_phase();
		write_reg(REG_UNUSED_3, 7'h00);
		feed(8'd200);
		finish_phase();

		// largest and clamped shapes, once each
		run_phase(63, 1, 1, 1'b0, 1'b0);
		run_phase(1, 127, 1, 1'b0, 1'b1);
		run_phase(32, 2, 1, 1'b0, 1'b0);
		run_phase(2, 64, 1, 1'b1, 1'b0);

		while (weights_queued < RAND_ITEMS) begin
			sel = $urandom_range(19);
			if (sel < 15) begin
				rows_d = $urandom_range(6, 1) | ($urandom_range(1) << 6);
				cols_d = $urandom_range(6, 1);
				grids = $urandom_range(4, 1);
			end else if (sel < 17) begin
				rows_d = $urandom_range(127);
				cols_d = $urandom_range(2);
				grids = $urandom_range(2, 1);
			end else if (sel < 19) begin
				rows_d = $urandom_range(3);
				cols_d = $urandom_range(127, 8);
				grids = 1;
			end else begin
				rows_d = $urandom_range(32, 7);
				cols_d = $urandom_range(6, 1);
				grids = 1;
			end
			run_phase(rows_d, cols_d, grids, $urandom_range(4) == 0, $urandom_range(9) == 0);
		end

		if (fail_count == 0)
			$display("min_cost_path_grid_wrap test passed");
		else
			$display("min_cost_path_grid_wrap test failed");
		$finish;
	end

endmodule
